// File: rtl/core/kfct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfct_pkg: shared definitions for the key frequency count table
// Sizes, operation codes, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package kfct_pkg;

  localparam int ENTRIES     = 64;
  localparam int COUNT_WIDTH = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OP_W        = 3;
  localparam int IN_KEY_W    = 32;
  localparam int RES_W       = 17;

  typedef enum logic [OP_W-1:0] {
    OP_INC    = 3'd0,
    OP_DEC    = 3'd1,
    OP_EJECT  = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_SEARCH = 3'd4,
    OP_MAX    = 3'd5
  } kfct_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_RESP
  } kfct_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // latch the item and restart the scan
    logic scan_rd;   // read the entry at the scan pointer and advance
    logic commit;    // form the result and write the table back
    logic out_load;  // move the result into the output register
  } kfct_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last; // the scan pointer sits on the last entry
    logic out_free;  // the output register can take a result this cycle
  } kfct_sts_t;

endpackage
`default_nettype wire

// File: rtl/core/kfct_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfct_ifs: channel interfaces of the key frequency count table
// One interface for the operation channel and one for the result channel,
// each a valid/ready handshake with its payload.
// ----------------------------------------------------------------------------
interface kfct_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] key;

  modport source (output valid, output op, output key, input ready);
  modport sink   (input valid, input op, input key, output ready);
endinterface

interface kfct_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] count;
  logic               found;
  logic               status;

  modport source (output valid, output count, output found, output status, input ready);
  modport sink   (input valid, input count, input found, input status, output ready);
endinterface
`default_nettype wire

// File: rtl/core/kfct_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfct_ctrl: sequencing controller
// Walks each item through accept, table scan, drain, write-back and result.
// ----------------------------------------------------------------------------
module kfct_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire kfct_pkg::kfct_sts_t sts,
  output kfct_pkg::kfct_cmd_t     cmd
);
  import kfct_pkg::*;

  kfct_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN:   if (sts.scan_last) state_nxt = ST_DRAIN;
      ST_DRAIN:  state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_RESP;
      ST_RESP:   if (sts.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN:   cmd.scan_rd  = 1'b1;
      ST_DRAIN:  cmd          = '0;
      ST_UPDATE: cmd.commit   = 1'b1;
      ST_RESP:   cmd.out_load = sts.out_free;
      default:   cmd          = '0;
    endcase
  end

  // The scan always ends in the drain cycle once the last entry is read.
  a_scan_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && sts.scan_last) |=> (state_r == ST_DRAIN))
    else $error("scan did not end after the last entry");

  // An accepted item always starts a scan.
  a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_SCAN && !$past(cmd.commit)))
    else $error("accepted item did not start a scan");

endmodule
`default_nettype wire

// File: rtl/core/kfct_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfct_dp: table datapath
// Holds the key and count memories and the valid bits, scans the entries
// one a cycle, writes the table back and keeps the output register.
// ----------------------------------------------------------------------------
module kfct_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [kfct_pkg::OP_W-1:0]          in_op,
  input  wire logic [kfct_pkg::IN_KEY_W-1:0]      in_key,
  input  wire kfct_pkg::kfct_cmd_t                cmd,
  output kfct_pkg::kfct_sts_t                     sts,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [kfct_pkg::RES_W-1:0]       out_count,
  output logic                                    out_found,
  output logic                                    out_status
);
  import kfct_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = '1;
  localparam logic [RES_W-1:0]       RES_NONE = '1;

  // Memories and valid bits.
  logic [KEY_WIDTH-1:0]   key_mem [ENTRIES];
  logic [COUNT_WIDTH-1:0] cnt_mem [ENTRIES];
  logic [ENTRIES-1:0]     valid_r, valid_nxt;

  // Item registers.
  logic [OP_W-1:0]      op_r;
  logic [KEY_WIDTH-1:0] key_r;

  // Scan pointer and read stage.
  logic [IDX_W-1:0]       scan_idx_r;
  logic                   rd_vld_r;
  logic [IDX_W-1:0]       rd_idx_r;
  logic [KEY_WIDTH-1:0]   key_rd_r;
  logic [COUNT_WIDTH-1:0] cnt_rd_r;

  // Scan accumulators.
  logic                   hit_r, free_r, any_r;
  logic [IDX_W-1:0]       hit_idx_r, free_idx_r;
  logic [COUNT_WIDTH-1:0] hit_cnt_r, max_r;

  // Result and output registers.
  logic [RES_W-1:0] res_cnt_r, res_cnt_nxt;
  logic             res_found_r, res_found_nxt;
  logic             res_status_r, res_status_nxt;
  logic             out_valid_r;
  logic [RES_W-1:0] out_cnt_r;
  logic             out_found_r, out_status_r;

  // Write port of the memories.
  logic                   cnt_we, key_we;
  logic [IDX_W-1:0]       wr_idx;
  logic [COUNT_WIDTH-1:0] cnt_wdata;

  function automatic logic [RES_W-1:0] to_res(input logic [COUNT_WIDTH-1:0] c);
    return {{(RES_W-COUNT_WIDTH){1'b0}}, c};
  endfunction

  assign sts.scan_last = (scan_idx_r == IDX_W'(ENTRIES - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      key_r <= in_key[KEY_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_rd;
      if (cmd.load) begin
        scan_idx_r <= '0;
      end else if (cmd.scan_rd) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= scan_idx_r;
    key_rd_r <= key_mem[scan_idx_r];
    cnt_rd_r <= cnt_mem[scan_idx_r];
  end

  // Compare stage: first match, lowest free entry, and highest count.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
      any_r      <= 1'b0;
      hit_idx_r  <= '0;
      free_idx_r <= '0;
      hit_cnt_r  <= '0;
      max_r      <= '0;
    end else if (rd_vld_r) begin
      if (valid_r[rd_idx_r]) begin
        any_r <= 1'b1;
        if (!any_r || cnt_rd_r > max_r) begin
          max_r <= cnt_rd_r;
        end
        if (!hit_r && key_rd_r == key_r) begin
          hit_r     <= 1'b1;
          hit_idx_r <= rd_idx_r;
          hit_cnt_r <= cnt_rd_r;
        end
      end else if (!free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= rd_idx_r;
      end
    end
  end

  // Write-back and result.
  always_comb begin
    valid_nxt      = valid_r;
    cnt_we         = 1'b0;
    key_we         = 1'b0;
    wr_idx         = hit_idx_r;
    cnt_wdata      = '0;
    res_cnt_nxt    = RES_NONE;
    res_found_nxt  = 1'b0;
    res_status_nxt = 1'b0;
    if (cmd.scan_rd && op_r == OP_CLEAR) begin
      cnt_we = 1'b1;
      wr_idx = scan_idx_r;
    end else if (cmd.commit) begin
      unique case (op_r)
        OP_INC: begin
          if (hit_r) begin
            cnt_we        = 1'b1;
            cnt_wdata     = (hit_cnt_r == CNT_MAX) ? hit_cnt_r : hit_cnt_r + 1'b1;
            res_cnt_nxt   = to_res(cnt_wdata);
            res_found_nxt = 1'b1;
          end else if (free_r) begin
            cnt_we              = 1'b1;
            key_we              = 1'b1;
            wr_idx              = free_idx_r;
            cnt_wdata           = COUNT_WIDTH'(1);
            valid_nxt[free_idx_r] = 1'b1;
            res_cnt_nxt         = to_res(cnt_wdata);
          end else begin
            res_status_nxt = 1'b1;
          end
        end
        OP_DEC: begin
          if (hit_r) begin
            cnt_we        = 1'b1;
            cnt_wdata     = (hit_cnt_r == '0) ? hit_cnt_r : hit_cnt_r - 1'b1;
            res_cnt_nxt   = to_res(cnt_wdata);
            res_found_nxt = 1'b1;
          end
        end
        OP_EJECT: begin
          if (hit_r) begin
            valid_nxt[hit_idx_r] = 1'b0;
            res_cnt_nxt          = to_res(hit_cnt_r);
            res_found_nxt        = 1'b1;
          end
        end
        OP_CLEAR: begin
          res_cnt_nxt = any_r ? '0 : RES_NONE;
        end
        OP_SEARCH: begin
          if (hit_r) begin
            res_cnt_nxt   = to_res(hit_cnt_r);
            res_found_nxt = 1'b1;
          end
        end
        OP_MAX: begin
          res_cnt_nxt = any_r ? to_res(max_r) : RES_NONE;
        end
        default: begin
          res_cnt_nxt = RES_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[wr_idx] <= cnt_wdata;
    end
    if (key_we) begin
      key_mem[wr_idx] <= key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_cnt_r    <= res_cnt_nxt;
      res_found_r  <= res_found_nxt;
      res_status_r <= res_status_nxt;
    end
    if (cmd.out_load) begin
      out_cnt_r    <= res_cnt_r;
      out_found_r  <= res_found_r;
      out_status_r <= res_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_count  = $signed(out_cnt_r);
  assign out_found  = out_found_r;
  assign out_status = out_status_r;

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten while stalled");

  // A key match implies at least one stored entry was seen.
  a_hit_any: assert property (@(posedge clk) disable iff (!rst_n)
    hit_r |-> any_r)
    else $error("match without any valid entry");

  // A full-table report only happens when every entry is in use.
  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && res_status_nxt) |-> (&valid_r))
    else $error("table full reported with a free entry");

endmodule
`default_nettype wire

// File: rtl/core/key_frequency_count_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// key_frequency_count_table: keyed access counter table
// Stores up to 64 keys with a saturating 16-bit count each and applies one
// operation per item: increment, decrement, eject, clear counts, search or
// find maximum.
//
// The input channel carries one item (op, key); the result channel returns
// exactly one item (count, found, status) for each, in order. Both channels
// use a valid/ready handshake.
//
// Each item is handled by a full scan of the table: the key and count
// memories have one read port, so the scan reads one entry per cycle
// through all 64 entries, then moves through a drain step, a write-back
// step and a step that loads the output register. The next item is
// accepted only after the previous one has left that last step, so items
// are handled one at a time.
//
// The output register lets the block accept the next item while a result is
// still waiting; if the receiver stalls, the following result is held inside
// the block until the output register is free. Reset clears every valid bit,
// so the table starts empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
module key_frequency_count_table (
  input  wire logic clk,
  input  wire logic rst_n,
  kfct_in_if.sink   in_ch,
  kfct_out_if.source out_ch
);
  import kfct_pkg::*;

  kfct_cmd_t cmd;
  kfct_sts_t sts;

  // The controller sequences the scan and handshakes; the datapath holds
  // the table and the result registers.
  kfct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kfct_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_op      (in_ch.op),
    .in_key     (in_ch.key),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_count  (out_ch.count),
    .out_found  (out_ch.found),
    .out_status (out_ch.status)
  );

endmodule
`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the key frequency count table
// Drives operation items through the input channel and checks every result
// against an in-bench model of the keyed count table. The run covers the
// empty table, the zero floor of decrement, eject and clear, a full table,
// unused operation codes and random traffic under varying handshake stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import kfct_pkg::*;

  // Codes 6 and 7 are not operations; the block must answer them with a
  // neutral result and leave the table alone.
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // The tail wait and the hold-off are sized from the time an item takes
  // from one accept to the next. The watchdog must outlast the hold-off
  // plus one item.
  localparam int TAIL_CYCLES   = 80;
  localparam int HOLDOFF_LEN   = 600;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT  = 10;

  typedef struct {
    logic signed [RES_W-1:0] count;
    logic                    found;
    logic                    status;
    logic [OP_W-1:0]         op;
    logic [IN_KEY_W-1:0]     key;
  } count_result_t;

  logic clk = 1'b0;
  logic rst_n;

  kfct_in_if  in_ch ();
  kfct_out_if out_ch ();

  key_frequency_count_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  // Shadow copy of the table. It is updated when an item is accepted, so it
  // always reflects every item the block has taken so far.
  logic [KEY_WIDTH-1:0]   tbl_key  [ENTRIES];
  logic [COUNT_WIDTH-1:0] tbl_cnt  [ENTRIES];
  bit                     tbl_used [ENTRIES];

  count_result_t pending_results[$];

  int send_idle = 23;
  int recv_idle = 52;
  int stall_req = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int n_items = 0;
  int n_results = 0;
  int n_full = 0;
  int n_fail = 0;

  // Applies one operation to the shadow table and returns the result the
  // block must produce for it. The operations need the entry that holds the
  // key, the lowest free entry and the largest stored count, so one pass
  // gathers all three before the operation is applied.
  function automatic count_result_t apply_table_op(input logic [OP_W-1:0] op,
                                                   input logic [IN_KEY_W-1:0] key_in);
    count_result_t r;
    logic [KEY_WIDTH-1:0] k;
    int hit;
    int slot;
    int best;
    r.op = op;
    r.key = key_in;
    r.count = '1;
    r.found = 1'b0;
    r.status = 1'b0;
    k = KEY_WIDTH'(key_in);
    hit = -1;
    slot = -1;
    best = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_used[i] && tbl_key[i] == k && hit < 0) hit = i;
      if (!tbl_used[i] && slot < 0) slot = i;
      if (tbl_used[i] && int'(tbl_cnt[i]) > best) best = int'(tbl_cnt[i]);
    end
    case (op)
      OP_INC: begin
        if (hit >= 0) begin
          r.found = 1'b1;
          if (tbl_cnt[hit] != COUNT_MAX) tbl_cnt[hit] = tbl_cnt[hit] + 1'b1;
          r.count = RES_W'(tbl_cnt[hit]);
        end else if (slot >= 0) begin
          // A new key always lands in the lowest free entry.
          tbl_used[slot] = 1'b1;
          tbl_key[slot] = k;
          tbl_cnt[slot] = 1;
          r.count = 1;
        end else begin
          r.status = 1'b1;
        end
      end
      OP_DEC: begin
        if (hit >= 0) begin
          r.found = 1'b1;
          if (tbl_cnt[hit] != '0) tbl_cnt[hit] = tbl_cnt[hit] - 1'b1;
          r.count = RES_W'(tbl_cnt[hit]);
        end
      end
      OP_EJECT: begin
        if (hit >= 0) begin
          r.found = 1'b1;
          r.count = RES_W'(tbl_cnt[hit]);
          tbl_used[hit] = 1'b0;
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_used[i]) begin
            tbl_cnt[i] = '0;
            r.count = '0;
          end
        end
      end
      OP_SEARCH: begin
        if (hit >= 0) begin
          r.found = 1'b1;
          r.count = RES_W'(tbl_cnt[hit]);
        end
      end
      OP_MAX: r.count = RES_W'(best);
      default: ;
    endcase
    return r;
  endfunction

  // Offers one item, with a random gap first, and waits for the handshake.
  // It is entered just after a rising edge, and it returns just after the
  // edge that took the item, so valid stays high into the next item when
  // no gap follows.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [IN_KEY_W-1:0] key);
    count_result_t r;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.key <= key;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = apply_table_op(op, key);
    if (r.status) n_full++;
    pending_results.push_back(r);
    n_items++;
  endtask

  // Empty-table answers, the zero floor of decrement, ejects of present and
  // absent keys, clear with and without keys, unused codes and the extreme
  // key patterns.
  task automatic test_directed();
    send_item(OP_SEARCH, 32'h0000_0000);
    send_item(OP_MAX, 32'h0000_0000);
    send_item(OP_CLEAR, 32'h0000_0000);
    send_item(OP_DEC, 32'h0000_0000);
    send_item(OP_EJECT, 32'hFFFF_FFFF);
    send_item(OP_RSVD6, 32'hFFFF_FFFF);
    send_item(OP_RSVD7, 32'h0000_0000);
    send_item(OP_INC, 32'h0000_0000);
    send_item(OP_INC, 32'h0000_0000);
    send_item(OP_INC, 32'hFFFF_FFFF);
    send_item(OP_SEARCH, 32'hFFFF_FFFF);
    send_item(OP_MAX, 32'h0000_0000);
    send_item(OP_DEC, 32'h0000_0000);
    send_item(OP_DEC, 32'hFFFF_FFFF);
    send_item(OP_DEC, 32'hFFFF_FFFF);
    send_item(OP_EJECT, 32'h0000_0000);
    send_item(OP_SEARCH, 32'h0000_0000);
    send_item(OP_INC, 32'hA5A5_5A5A);
    send_item(OP_INC, 32'h0000_0000);
    send_item(OP_CLEAR, 32'hFFFF_FFFF);
    send_item(OP_MAX, 32'hFFFF_FFFF);
    send_item(OP_SEARCH, 32'hA5A5_5A5A);
    send_item(OP_DEC, 32'hA5A5_5A5A);
    send_item(OP_RSVD7, 32'hA5A5_5A5A);
    send_item(OP_EJECT, 32'hFFFF_FFFF);
  endtask

  // Empties the table, fills every entry with distinct keys and then pushes
  // a new key into the full table. An increment of a stored key must still
  // work while full, and an eject must open exactly one entry again.
  task automatic test_table_full();
    logic [IN_KEY_W-1:0] present[$];
    logic [IN_KEY_W-1:0] fresh[$];
    logic [IN_KEY_W-1:0] k;
    bit dup;
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_used[i]) present.push_back(IN_KEY_W'(tbl_key[i]));
    end
    foreach (present[i]) send_item(OP_EJECT, present[i]);
    while (fresh.size() < ENTRIES + 2) begin
      k = $urandom;
      dup = 1'b0;
      foreach (fresh[j]) if (fresh[j] == k) dup = 1'b1;
      if (!dup) fresh.push_back(k);
    end
    for (int i = 0; i < ENTRIES; i++) send_item(OP_INC, fresh[i]);
    send_item(OP_INC, fresh[ENTRIES]);
    send_item(OP_SEARCH, fresh[ENTRIES]);
    send_item(OP_INC, fresh[5]);
    send_item(OP_MAX, 32'h0000_0000);
    send_item(OP_EJECT, fresh[20]);
    send_item(OP_INC, fresh[ENTRIES]);
    send_item(OP_INC, fresh[ENTRIES + 1]);
    send_item(OP_CLEAR, 32'h0000_0000);
  endtask

  // Random traffic. Most keys come from a pool so that searches, decrements
  // and ejects find stored keys; the pool is sometimes small, giving high
  // counts, and sometimes large, pushing the table toward full. A tenth of
  // the keys are fresh random patterns.
  task automatic test_random(input int n_ops, input int s_idle, input int r_idle);
    logic [IN_KEY_W-1:0] pool[80];
    int pool_n;
    int pick;
    logic [OP_W-1:0] op;
    logic [IN_KEY_W-1:0] key;
    send_idle = s_idle;
    recv_idle = r_idle;
    pool_n = 8;
    foreach (pool[i]) pool[i] = $urandom;
    for (int i = 0; i < n_ops; i++) begin
      if (i % 40 == 0) pool_n = ($urandom_range(1) == 1) ? 80 : $urandom_range(3, 12);
      pick = $urandom_range(99);
      if (pick < 40) op = OP_INC;
      else if (pick < 55) op = OP_DEC;
      else if (pick < 65) op = OP_EJECT;
      else if (pick < 69) op = OP_CLEAR;
      else if (pick < 82) op = OP_SEARCH;
      else if (pick < 94) op = OP_MAX;
      else op = ($urandom_range(1) == 1) ? OP_RSVD6 : OP_RSVD7;
      key = ($urandom_range(9) == 0) ? IN_KEY_W'($urandom) : pool[$urandom_range(pool_n - 1)];
      send_item(op, key);
    end
  endtask

  // The receiver holds off for a long stretch while items keep coming, so
  // the output register and the internal result both fill and the block has
  // to stall its input.
  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    stall_req = HOLDOFF_LEN;
    for (int i = 0; i < 12; i++) begin
      send_item(($urandom_range(1) == 1) ? OP_INC : OP_SEARCH, IN_KEY_W'($urandom_range(3)));
    end
  endtask

  // Result side: checks each accepted result against the oldest expectation
  // and then decides ready for the next cycle. Values read here are those
  // from before the edge, since the block and this bench update on it with
  // nonblocking assignments.
  always @(posedge clk) begin : result_monitor
    count_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        n_fail++;
        if (n_fail <= REPORT_LIMIT) begin
          $display("unexpected result: count %0d found %0b status %0b",
                   out_ch.count, out_ch.found, out_ch.status);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_ch.count !== want.count || out_ch.found !== want.found ||
            out_ch.status !== want.status) begin
          n_fail++;
          if (n_fail <= REPORT_LIMIT) begin
            $display("mismatch op %0d key %h: count %0d/%0d found %0b/%0b status %0b/%0b",
                     want.op, want.key, want.count, out_ch.count, want.found,
                     out_ch.found, want.status, out_ch.status);
          end
        end
      end
    end
    if (stall_req > 0) begin
      stall_left = stall_req;
      stall_req = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Ends a hung run: too many cycles in a row with no item moving on either
  // channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = OP_INC;
    in_ch.key = '0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    foreach (tbl_used[i]) begin
      tbl_used[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_cnt[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_table_full();
    test_random(140, 23, 52);
    test_random(140, 52, 23);
    test_backpressure();
    test_random(140, 0, 0);
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d items and checked %0d results over all operations and unused codes;",
             n_items, n_results);
    $display("%0d increments met a full table; count saturation lies beyond this run.",
             n_full);
    if (n_fail == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
